[rtl/sliding_window_statistics_defines.svh]
// assertion macros for the sliding window statistics controller
`ifndef SLIDING_WINDOW_STATISTICS_DEFINES_SVH
`define SLIDING_WINDOW_STATISTICS_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define SWS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define SWS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sws_pkg.sv]
// shared types and constants for the sliding window statistics block
`timescale 1ns / 1ps
`default_nettype none

package sws_pkg;

  localparam int WINDOW_MAX = 256;
  localparam int ADDR_W     = $clog2(WINDOW_MAX);
  localparam int LEN_W      = 9;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 24;
  localparam int SQ_W       = 40;
  localparam int DIV_W      = 40;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int VAR_W      = 32;
  localparam int BAL_W      = 10;

  typedef struct packed {
    logic take;
    logic store;
    logic scan;
    logic pass;
    logic div_start;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic len_zero;
  } status_t;

endpackage

`default_nettype wire

[rtl/sws_div.sv]
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module sws_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [sws_pkg::DIV_W-1:0] dividend,
  input  wire logic [sws_pkg::LEN_W-1:0] divisor,
  output logic                           done,
  output logic      [sws_pkg::DIV_W-1:0] quotient
);

  logic                          busy;
  logic [sws_pkg::DIV_CNT_W-1:0] cnt;
  logic [sws_pkg::LEN_W-1:0]     rem;
  logic [sws_pkg::LEN_W:0]       trial;
  logic                          fits;

  assign trial = {rem, quotient[sws_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? sws_pkg::LEN_W'(trial - {1'b0, divisor})
                         : trial[sws_pkg::LEN_W-1:0];
        quotient <= {quotient[sws_pkg::DIV_W-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == sws_pkg::DIV_CNT_W'(sws_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sws_dp.sv]
// datapath: sample ring, scan accumulators, divider and result registers
`timescale 1ns / 1ps
`default_nettype none

module sws_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sws_pkg::cmd_t                cmd,
  output sws_pkg::status_t                  stat,
  input  wire logic                         cfg_we,
  input  wire logic    [sws_pkg::LEN_W-1:0] window_length,
  input  wire logic signed [sws_pkg::SAMPLE_W-1:0] sample,
  output logic         [sws_pkg::SAMPLE_W-1:0] abs_max,
  output logic signed  [sws_pkg::SUM_W-1:0]    total,
  output logic signed  [sws_pkg::SAMPLE_W-1:0] mean,
  output logic         [sws_pkg::SAMPLE_W-1:0] spread,
  output logic         [sws_pkg::VAR_W-1:0]    variance,
  output logic signed  [sws_pkg::BAL_W-1:0]    sign_balance,
  output logic         [sws_pkg::LEN_W-1:0]    fill_count
);

  logic [sws_pkg::SAMPLE_W-1:0] mem [sws_pkg::WINDOW_MAX];

  logic [sws_pkg::LEN_W-1:0]    wlen;
  logic [sws_pkg::LEN_W-1:0]    len_eff;
  logic [sws_pkg::LEN_W-1:0]    fill;
  logic [sws_pkg::LEN_W-1:0]    slot;
  logic [sws_pkg::LEN_W-1:0]    slot_use;
  logic [sws_pkg::ADDR_W-1:0]   wr_addr;
  logic [sws_pkg::SAMPLE_W-1:0] sample_q;

  logic [sws_pkg::LEN_W-1:0]    rd_idx;
  logic                         issue;
  logic                         rd_v;
  logic                         sq_v;
  logic [sws_pkg::SAMPLE_W-1:0] rd_data;

  logic [sws_pkg::SAMPLE_W-1:0]        amax;
  logic [sws_pkg::SAMPLE_W-1:0]        ax;
  logic signed [sws_pkg::SAMPLE_W-1:0] x;
  logic signed [sws_pkg::SAMPLE_W-1:0] mx;
  logic signed [sws_pkg::SAMPLE_W-1:0] mn;
  logic signed [sws_pkg::SUM_W-1:0]    sum;
  logic signed [sws_pkg::BAL_W-1:0]    bal;
  logic signed [sws_pkg::SAMPLE_W-1:0] mean_q;
  logic signed [sws_pkg::SAMPLE_W:0]   dev;
  logic signed [2*sws_pkg::SAMPLE_W+1:0] dev_sq;
  logic [sws_pkg::VAR_W-1:0]           prod;
  logic [sws_pkg::SQ_W-1:0]            sq;
  logic [sws_pkg::VAR_W-1:0]           var_q;

  logic [sws_pkg::SUM_W-1:0]  sum_mag;
  logic [sws_pkg::DIV_W-1:0]  dividend;
  logic [sws_pkg::DIV_W-1:0]  quotient;
  logic                       div_done;

  assign len_eff  = (wlen > sws_pkg::LEN_W'(sws_pkg::WINDOW_MAX))
                    ? sws_pkg::LEN_W'(sws_pkg::WINDOW_MAX) : wlen;
  assign slot_use = (slot >= len_eff) ? '0 : slot;
  assign wr_addr  = (fill < len_eff) ? fill[sws_pkg::ADDR_W-1:0]
                                     : slot_use[sws_pkg::ADDR_W-1:0];
  assign issue    = cmd.scan && (rd_idx < fill);

  assign x  = $signed(rd_data);
  assign ax = rd_data[sws_pkg::SAMPLE_W-1] ? (~rd_data + 1'b1) : rd_data;
  assign dev    = $signed({x[sws_pkg::SAMPLE_W-1], x})
                - $signed({mean_q[sws_pkg::SAMPLE_W-1], mean_q});
  assign dev_sq = dev * dev;

  assign sum_mag  = sum[sws_pkg::SUM_W-1] ? sws_pkg::SUM_W'(-sum) : sws_pkg::SUM_W'(sum);
  assign dividend = cmd.pass ? sq : sws_pkg::DIV_W'(sum_mag);

  assign stat.scan_done = (rd_idx >= fill) && !rd_v && !sq_v;
  assign stat.div_done  = div_done;
  assign stat.len_zero  = (len_eff == '0);

  sws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (len_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // ring storage, registered read
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[wr_addr] <= sample_q;
    end
    rd_data <= mem[rd_idx[sws_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen   <= '0;
      fill   <= '0;
      slot   <= '0;
      rd_idx <= '0;
      rd_v   <= 1'b0;
      sq_v   <= 1'b0;
    end else begin
      if (cfg_we) begin
        wlen <= window_length;
        fill <= '0;
        slot <= '0;
      end else if (cmd.store) begin
        if (fill < len_eff) begin
          fill <= fill + 1'b1;
        end else begin
          slot <= slot_use + 1'b1;
        end
      end
      rd_idx <= cmd.scan ? (issue ? rd_idx + 1'b1 : rd_idx) : '0;
      rd_v   <= issue;
      sq_v   <= rd_v && cmd.pass;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sample_q <= sample;
    end
    if (cmd.store) begin
      amax <= '0;
      mx   <= {1'b1, {(sws_pkg::SAMPLE_W-1){1'b0}}};
      mn   <= {1'b0, {(sws_pkg::SAMPLE_W-1){1'b1}}};
      sum  <= '0;
      bal  <= '0;
      sq   <= '0;
    end else begin
      if (rd_v && !cmd.pass) begin
        if (ax > amax) amax <= ax;
        if (x > mx) mx <= x;
        if (x < mn) mn <= x;
        bal <= (x > 0) ? bal + 1'b1 : bal - 1'b1;
        sum <= sum + sws_pkg::SUM_W'(x);
      end
      if (sq_v) begin
        sq <= sq + sws_pkg::SQ_W'(prod);
      end
    end
    prod <= dev_sq[sws_pkg::VAR_W-1:0];
    if (div_done && !cmd.pass) begin
      mean_q <= sum[sws_pkg::SUM_W-1] ? -quotient[sws_pkg::SAMPLE_W-1:0]
                                      : quotient[sws_pkg::SAMPLE_W-1:0];
    end
    if (div_done && cmd.pass) begin
      var_q <= (quotient[sws_pkg::DIV_W-1:sws_pkg::VAR_W] != '0)
               ? '1 : quotient[sws_pkg::VAR_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (stat.len_zero) begin
        abs_max      <= '0;
        total        <= '0;
        mean         <= '0;
        spread       <= '0;
        variance     <= '0;
        sign_balance <= '0;
        fill_count   <= '0;
      end else begin
        abs_max      <= amax;
        total        <= sum;
        mean         <= mean_q;
        spread       <= sws_pkg::SAMPLE_W'(mx - mn);
        variance     <= var_q;
        sign_balance <= bal;
        fill_count   <= fill;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sws_ctrl.sv]
// controller: sequences store, two scans, two divisions and result hand-off, or hand-off alone for a zero length
`timescale 1ns / 1ps
`default_nettype none

`include "sliding_window_statistics_defines.svh"

module sws_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             sample_valid,
  output logic                  ready,
  output logic                  result_valid,
  input  wire logic             result_ready,
  input  wire sws_pkg::status_t stat,
  output sws_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_SCAN1,
    S_DIV1,
    S_SCAN2,
    S_DIV2,
    S_DONE
  } state_t;

  state_t state;
  logic   store_q;
  logic   scan_q;
  logic   pass_q;
  logic   start_q;
  logic   take;
  logic   load;

  assign take = sample_valid && ready;
  assign load = (state == S_DONE) && (!result_valid || result_ready);

  always_comb begin
    cmd.take      = take;
    cmd.store     = store_q;
    cmd.scan      = scan_q;
    cmd.pass      = pass_q;
    cmd.div_start = start_q;
    cmd.load      = load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ready        <= 1'b1;
      result_valid <= 1'b0;
      store_q      <= 1'b0;
      scan_q       <= 1'b0;
      pass_q       <= 1'b0;
      start_q      <= 1'b0;
    end else begin
      store_q <= 1'b0;
      start_q <= 1'b0;
      if (result_valid && result_ready) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            ready <= 1'b0;
            if (stat.len_zero) begin
              state <= S_DONE;
            end else begin
              state   <= S_STORE;
              store_q <= 1'b1;
            end
          end
        end
        S_STORE: begin
          state  <= S_SCAN1;
          scan_q <= 1'b1;
          pass_q <= 1'b0;
        end
        S_SCAN1: begin
          if (stat.scan_done) begin
            scan_q  <= 1'b0;
            start_q <= 1'b1;
            state   <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (stat.div_done) begin
            state  <= S_SCAN2;
            scan_q <= 1'b1;
            pass_q <= 1'b1;
          end
        end
        S_SCAN2: begin
          if (stat.scan_done) begin
            scan_q  <= 1'b0;
            start_q <= 1'b1;
            state   <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (stat.div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            result_valid <= 1'b1;
            ready        <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SWS_ASSERT_NEXT(a_take_leaves_idle, take, state == S_STORE || state == S_DONE, "take did not start work")
  `SWS_ASSERT_SAME(a_div_done_in_div, stat.div_done, state == S_DIV1 || state == S_DIV2, "stray divider done")
  `SWS_ASSERT_NEXT(a_load_sets_valid, load, result_valid && ready, "load did not present word")

endmodule

`default_nettype wire

[rtl/sliding_window_statistics.sv]
// top level of the sliding window statistics block
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   sample   | sample_valid/ready     | sample
//   config   | cfg_valid/cfg_ready    | window_length
//   result   | result_valid/ready     | abs_max total mean spread variance
//            |                        | sign_balance fill_count
//
// one word runs from the accepted sample to the result through two passes
// over the single read port of the sample ring and two 40-step divisions
// by the length
// a length of zero skips the work and returns zeros
// rst is synchronous; it empties the window and sets the length to zero
// a finished word waits in the output register while the next sample is taken
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_statistics (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sample_valid,
  output logic             sample_ready,
  input  wire logic signed [15:0] sample,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  window_length,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [15:0]      abs_max,
  output logic signed [23:0] total,
  output logic signed [15:0] mean,
  output logic [15:0]      spread,
  output logic [31:0]      variance,
  output logic signed [9:0] sign_balance,
  output logic [8:0]       fill_count
);

  sws_pkg::cmd_t    cmd;
  sws_pkg::status_t stat;
  logic             ready;
  logic             cfg_we;

  assign sample_ready = ready;
  assign cfg_ready    = ready;
  assign cfg_we       = cfg_valid && ready;

  sws_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .ready        (ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  sws_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .window_length (window_length),
    .sample        (sample),
    .abs_max       (abs_max),
    .total         (total),
    .mean          (mean),
    .spread        (spread),
    .variance      (variance),
    .sign_balance  (sign_balance),
    .fill_count    (fill_count)
  );

endmodule

`default_nettype wire
